/* rtl/core/sme_pkg.sv */
// Shared constants, opcodes, command/status structs and decode helpers
// for the stack machine executor. No dependencies.
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_WORDS  = 1024;
    localparam int CODE_BYTES  = 4096;

    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DA_W  = $clog2(DATA_WORDS);
    localparam int LEN_W = 13;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_HALT = 8'h01;
    localparam logic [7:0] OP_PUSH = 8'h02;
    localparam logic [7:0] OP_POP  = 8'h03;
    localparam logic [7:0] OP_DUP  = 8'h04;
    localparam logic [7:0] OP_ADD  = 8'h10;
    localparam logic [7:0] OP_SUB  = 8'h11;
    localparam logic [7:0] OP_MUL  = 8'h12;
    localparam logic [7:0] OP_DIV  = 8'h13;
    localparam logic [7:0] OP_MOD  = 8'h14;
    localparam logic [7:0] OP_AND  = 8'h20;
    localparam logic [7:0] OP_OR   = 8'h21;
    localparam logic [7:0] OP_XOR  = 8'h22;
    localparam logic [7:0] OP_NOT  = 8'h23;
    localparam logic [7:0] OP_EQ   = 8'h30;
    localparam logic [7:0] OP_NEQ  = 8'h31;
    localparam logic [7:0] OP_LT   = 8'h32;
    localparam logic [7:0] OP_GT   = 8'h33;
    localparam logic [7:0] OP_JMP  = 8'h40;
    localparam logic [7:0] OP_JZ   = 8'h41;
    localparam logic [7:0] OP_JNZ  = 8'h42;
    localparam logic [7:0] OP_LOAD = 8'h60;
    localparam logic [7:0] OP_STOR = 8'h61;
    localparam logic [7:0] OP_PRTD = 8'h70;
    localparam logic [7:0] OP_PRTT = 8'h71;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic pop_cap;
        logic div_start;
        logic exec;
        logic push;
        logic finish;
    } sme_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       can_run;
        logic [1:0] pops;
        logic [1:0] pushes;
        logic       is_load;
        logic       is_div;
        logic       div_busy;
        logic       out_free;
    } sme_stat_t;

    function automatic logic [1:0] pop_count(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (op inside {OP_POP, OP_DUP, OP_NOT, OP_JZ, OP_JNZ, OP_LOAD, OP_PRTD, OP_PRTT})
            n = 2'd1;
        else if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
                            OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_STOR})
            n = 2'd2;
        return n;
    endfunction

    function automatic logic [1:0] push_count(input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (op == OP_DUP)
            n = 2'd2;
        else if (op inside {OP_PUSH, OP_NOT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND,
                            OP_OR, OP_XOR, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LOAD})
            n = 2'd1;
        return n;
    endfunction

    function automatic logic has_imm(input logic [7:0] op);
        return op inside {OP_PUSH, OP_JMP, OP_JZ, OP_JNZ};
    endfunction

    function automatic logic is_known(input logic [7:0] op);
        return op inside {OP_NOP, OP_HALT, OP_PUSH, OP_POP, OP_DUP, OP_ADD, OP_SUB, OP_MUL,
                          OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_EQ, OP_NEQ,
                          OP_LT, OP_GT, OP_JMP, OP_JZ, OP_JNZ, OP_LOAD, OP_STOR, OP_PRTD,
                          OP_PRTT};
    endfunction

endpackage

/* rtl/core/sme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sme_div.sv */
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// No dependencies.
module sme_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  bit_reg;
    logic        busy_reg;
    logic [32:0] r_shift;
    logic [32:0] diff;

    assign r_shift = {r_reg, q_reg[31]};
    assign diff    = r_shift - {1'b0, d_reg};

    always_comb
    begin
        if (!diff[32])
        begin
            r_next = diff[31:0];
            q_next = {q_reg[30:0], 1'b1};
        end
        else
        begin
            r_next = r_shift[31:0];
            q_next = {q_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            bit_reg <= bit_reg - 6'd1;
            if (bit_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

/* rtl/core/sme_datapath.sv */
// Datapath: operand stack, data memory, program counter, ALU, output register.
// Depends on sme_pkg, sme_ram and sme_div.
module sme_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sme_pkg::sme_cmd_t            cmd,
    output sme_pkg::sme_stat_t           stat,
    input  logic [7:0]                   func,
    input  logic [31:0]                  immediate,
    input  logic [sme_pkg::LEN_W-1:0]    program_length,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [71:0]                  m_tdata,
    output logic                         m_tuser
);

    logic [7:0]                  op_reg;
    logic [31:0]                 imm_reg;
    logic [31:0]                 pc_reg;
    logic [31:0]                 pc_new_reg, pc_new_next;
    logic [sme_pkg::CNT_W-1:0]   cnt_reg;
    logic                        running_reg;
    logic [1:0]                  cause_reg;
    logic                        exec_reg;
    logic [31:0]                 t1_reg, t2_reg;
    logic [31:0]                 res_reg, res_next;
    logic                        pvalid_reg;
    logic [sme_pkg::DA_W-1:0]    clr_reg;
    logic                        m_tvalid_reg;
    logic [71:0]                 m_tdata_reg;
    logic                        m_tuser_reg;

    logic [31:0] len;
    logic [31:0] pc1, nleft, nsat, imm_mask;
    logic [31:0] stk_rdata, dm_rdata;
    logic        stk_we, dm_we;
    logic [sme_pkg::DA_W-1:0] dm_waddr;
    logic [31:0] dm_wdata;
    logic        addr_ok;
    logic        div_busy;
    logic [31:0] div_q, div_r, ua, ub;
    logic        fin_running;
    logic [1:0]  fin_cause;
    logic [31:0] fin_pc;

    assign len = (32'(program_length) < 32'(sme_pkg::CODE_BYTES)) ?
                 32'(program_length) : 32'(sme_pkg::CODE_BYTES);

    assign pc1   = pc_reg + 32'd1;
    assign nleft = len - pc1;
    assign nsat  = (nleft > 32'd4) ? 32'd4 : nleft;

    always_comb
    begin
        case (nsat[2:0])
            3'd0:    imm_mask = 32'h0000_0000;
            3'd1:    imm_mask = 32'h0000_00FF;
            3'd2:    imm_mask = 32'h0000_FFFF;
            3'd3:    imm_mask = 32'h00FF_FFFF;
            default: imm_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign addr_ok = t1_reg < 32'(sme_pkg::DATA_WORDS);
    assign ua = t1_reg[31] ? 32'd0 - t1_reg : t1_reg;
    assign ub = t2_reg[31] ? 32'd0 - t2_reg : t2_reg;

    sme_ram #(.WIDTH(32), .DEPTH(sme_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (cnt_reg[sme_pkg::SP_W-1:0]),
        .wdata (res_reg),
        .raddr (sme_pkg::SP_W'(cnt_reg - sme_pkg::CNT_W'(1))),
        .rdata (stk_rdata)
    );

    assign stk_we = cmd.push && (cnt_reg < sme_pkg::CNT_W'(sme_pkg::STACK_DEPTH));

    sme_ram #(.WIDTH(32), .DEPTH(sme_pkg::DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (t1_reg[sme_pkg::DA_W-1:0]),
        .rdata (dm_rdata)
    );

    always_comb
    begin
        if (cmd.clear)
        begin
            dm_we    = 1'b1;
            dm_waddr = clr_reg;
            dm_wdata = '0;
        end
        else
        begin
            dm_we    = cmd.exec && (op_reg == sme_pkg::OP_STOR) && addr_ok;
            dm_waddr = t1_reg[sme_pkg::DA_W-1:0];
            dm_wdata = t2_reg;
        end
    end

    sme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ua),
        .divisor  (ub),
        .busy     (div_busy),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        res_next    = t1_reg;
        pc_new_next = pc_new_reg;
        case (op_reg)
            sme_pkg::OP_PUSH: res_next = imm_reg;
            sme_pkg::OP_ADD:  res_next = t1_reg + t2_reg;
            sme_pkg::OP_SUB:  res_next = t1_reg - t2_reg;
            sme_pkg::OP_MUL:  res_next = 32'(t1_reg * t2_reg);
            sme_pkg::OP_DIV:
                res_next = (t2_reg == 32'd0) ? 32'd0 :
                           (t1_reg[31] != t2_reg[31]) ? 32'd0 - div_q : div_q;
            sme_pkg::OP_MOD:
                res_next = (t2_reg == 32'd0) ? 32'd0 :
                           t1_reg[31] ? 32'd0 - div_r : div_r;
            sme_pkg::OP_AND:  res_next = t1_reg & t2_reg;
            sme_pkg::OP_OR:   res_next = t1_reg | t2_reg;
            sme_pkg::OP_XOR:  res_next = t1_reg ^ t2_reg;
            sme_pkg::OP_NOT:  res_next = {31'd0, t1_reg == 32'd0};
            sme_pkg::OP_EQ:   res_next = {31'd0, t1_reg == t2_reg};
            sme_pkg::OP_NEQ:  res_next = {31'd0, t1_reg != t2_reg};
            sme_pkg::OP_LT:   res_next = {31'd0, $signed(t1_reg) < $signed(t2_reg)};
            sme_pkg::OP_GT:   res_next = {31'd0, $signed(t2_reg) < $signed(t1_reg)};
            sme_pkg::OP_LOAD: res_next = addr_ok ? dm_rdata : 32'd0;
            sme_pkg::OP_JMP:  pc_new_next = imm_reg;
            sme_pkg::OP_JZ:   pc_new_next = (t1_reg == 32'd0) ? imm_reg : pc_new_reg;
            sme_pkg::OP_JNZ:  pc_new_next = (t1_reg != 32'd0) ? imm_reg : pc_new_reg;
            default:          res_next = t1_reg;
        endcase
    end

    always_comb
    begin
        fin_running = running_reg;
        fin_cause   = cause_reg;
        fin_pc      = exec_reg ? pc_new_reg : pc_reg;
        if (exec_reg && running_reg && (pc_new_reg >= len))
        begin
            fin_running = 1'b0;
            fin_cause   = sme_pkg::ST_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pc_reg       <= '0;
            running_reg  <= 1'b1;
            cause_reg    <= sme_pkg::ST_RUN;
            exec_reg     <= 1'b0;
            pvalid_reg   <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + sme_pkg::DA_W'(1);
            end
            if (cmd.start)
            begin
                pvalid_reg <= 1'b0;
                exec_reg   <= 1'b0;
                if (running_reg && (pc_reg >= len))
                begin
                    running_reg <= 1'b0;
                    cause_reg   <= sme_pkg::ST_END;
                end
                else if (running_reg)
                begin
                    exec_reg <= 1'b1;
                end
            end
            if (cmd.pop_cap && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - sme_pkg::CNT_W'(1);
            end
            if (cmd.exec)
            begin
                pvalid_reg <= (op_reg == sme_pkg::OP_PRTD) || (op_reg == sme_pkg::OP_PRTT);
                if (op_reg == sme_pkg::OP_HALT)
                begin
                    running_reg <= 1'b0;
                    cause_reg   <= sme_pkg::ST_HALT;
                end
                else if (!sme_pkg::is_known(op_reg))
                begin
                    running_reg <= 1'b0;
                    cause_reg   <= sme_pkg::ST_BADOP;
                end
            end
            if (stk_we)
            begin
                cnt_reg <= cnt_reg + sme_pkg::CNT_W'(1);
            end
            if (cmd.finish)
            begin
                pc_reg       <= fin_pc;
                running_reg  <= fin_running;
                cause_reg    <= fin_cause;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= func;
            imm_reg <= immediate;
        end
        if (cmd.start)
        begin
            if (sme_pkg::has_imm(op_reg))
            begin
                imm_reg    <= imm_reg & imm_mask;
                pc_new_reg <= pc1 + nsat;
            end
            else
            begin
                pc_new_reg <= pc1;
            end
        end
        if (cmd.pop_cap)
        begin
            t2_reg <= t1_reg;
            t1_reg <= (cnt_reg != '0) ? stk_rdata : 32'd0;
        end
        else if (cmd.start)
        begin
            t1_reg <= '0;
        end
        if (cmd.exec)
        begin
            res_reg    <= res_next;
            pc_new_reg <= pc_new_next;
        end
        if (cmd.finish)
        begin
            m_tdata_reg[31:0]  <= fin_pc;
            m_tdata_reg[32]    <= pvalid_reg;
            m_tdata_reg[64:33] <= pvalid_reg ? t1_reg : 32'd0;
            m_tdata_reg[66:65] <= fin_running ? sme_pkg::ST_RUN : fin_cause;
            m_tdata_reg[71:67] <= '0;
            m_tuser_reg        <= pvalid_reg && op_reg[0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.clr_last = clr_reg == sme_pkg::DA_W'(sme_pkg::DATA_WORDS - 1);
    assign stat.can_run  = running_reg && (pc_reg < len);
    assign stat.pops     = sme_pkg::pop_count(op_reg);
    assign stat.pushes   = sme_pkg::push_count(op_reg);
    assign stat.is_load  = op_reg == sme_pkg::OP_LOAD;
    assign stat.is_div   = (op_reg == sme_pkg::OP_DIV) || (op_reg == sme_pkg::OP_MOD);
    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sme_pkg::CNT_W'(sme_pkg::STACK_DEPTH))
        else $error("stack count past depth");
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |=> !running_reg)
        else $error("block restarted without reset");
    a_cause_run: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> cause_reg == sme_pkg::ST_RUN)
        else $error("stop cause set while running");
    a_stopped_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !exec_reg) |=> $stable(pc_reg))
        else $error("counter moved on a skipped item");
`endif

endmodule

/* rtl/core/sme_ctrl.sv */
// Controller state machine: sequences clear sweep, pops, load, divide,
// execute, pushes and result transfer. Depends on sme_pkg.
module sme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sme_pkg::sme_stat_t  stat,
    output sme_pkg::sme_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_POP_RD,
        S_POP_CAP,
        S_LD_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EXEC,
        S_PUSH,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] pops_reg, pops_next;
    logic [1:0] push_reg, push_next;
    state_t     after_pops;

    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        if (stat.is_load)
            after_pops = S_LD_RD;
        else if (stat.is_div)
            after_pops = S_DIV_GO;
        else
            after_pops = S_EXEC;
    end

    always_comb
    begin
        state_next = state_reg;
        pops_next  = pops_reg;
        push_next  = push_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
                pops_next = stat.pops;
                if (!stat.can_run)
                    state_next = S_FINISH;
                else if (stat.pops != 2'd0)
                    state_next = S_POP_RD;
                else
                    state_next = S_EXEC;
            end
            S_POP_RD:
                state_next = S_POP_CAP;
            S_POP_CAP:
            begin
                cmd.pop_cap = 1'b1;
                pops_next   = pops_reg - 2'd1;
                state_next  = (pops_reg == 2'd1) ? after_pops : S_POP_RD;
            end
            S_LD_RD:
                state_next = S_EXEC;
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                push_next  = stat.pushes;
                state_next = (stat.pushes != 2'd0) ? S_PUSH : S_FINISH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                push_next  = push_reg - 2'd1;
                if (push_reg == 2'd1)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pops_reg  <= '0;
            push_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pops_reg  <= pops_next;
            push_reg  <= push_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input taken during clear sweep");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_GO) |=> stat.div_busy)
        else $error("divider did not start");
    a_push_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_PUSH) |-> $past(state_reg == S_EXEC))
        else $error("push without execute");
`endif

endmodule

/* rtl/core/stack_machine_executor.sv */
// Top level of the stack machine executor: joins controller and datapath.
// Depends on sme_pkg, sme_ctrl, sme_datapath (and through it sme_ram, sme_div).
//
//  channel   | dir | handshake          | payload
//  s_*       | in  | s_tvalid/s_tready  | tdata: func[7:0], immediate[39:8]
//  m_*       | out | m_tvalid/m_tready  | tdata: next_pc, print_valid, print_value,
//            |     |                    |   run_status; tuser: print_mode
//  cfg_*     | in  | cfg_we             | cfg_wdata: program_length
//
// One item at a time: take, start, execute and finish, plus a read and a capture per popped operand
// and a push per value; load adds a read, divide and modulo wait on the bit-serial divider.
// An item taken once stopped, or with the counter at the program end, goes straight to finish.
// After reset a sweep clears every data memory word; no input is taken then.
// A held result stalls the executor only in its last step.
module stack_machine_executor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // func, immediate
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,   // next_pc, print_valid, print_value, run_status
    output logic                        m_tuser,   // print_mode
    input  logic                        cfg_we,
    input  logic [sme_pkg::LEN_W-1:0]   cfg_wdata
);

    sme_pkg::sme_cmd_t           cmd;
    sme_pkg::sme_stat_t          stat;
    logic [sme_pkg::LEN_W-1:0]   len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cfg_we)
            len_reg <= cfg_wdata;
    end

    sme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sme_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (s_tdata[7:0]),
        .immediate      (s_tdata[39:8]),
        .program_length (len_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

/* tb/stack_machine_executor_test.sv */
// Self-checking testbench for stack_machine_executor: directed table, then random programs.
// Results are compared against an in-bench predictor of the executor state.
// Depends on sme_pkg and the executor RTL.
module stack_machine_executor_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        print_valid;
        logic        print_mode;
        logic [31:0] print_value;
        logic [1:0]  run_status;
    } exec_result_t;

    typedef struct {
        logic [7:0]   func;
        logic [31:0]  imm;
        bit           typed;
        exec_result_t result;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [sme_pkg::LEN_W-1:0] cfg_wdata;

    exec_result_t pending_results[$];
    int           errors;
    bit           no_idle;

    logic [31:0] model_stack[sme_pkg::STACK_DEPTH];
    int          model_depth;
    logic [31:0] model_mem[sme_pkg::DATA_WORDS];
    logic [31:0] model_pc;
    bit          model_running;
    logic [1:0]  model_cause;
    logic [31:0] model_len;

    logic [7:0] misc_ops[19] = '{
        sme_pkg::OP_NOP, sme_pkg::OP_POP, sme_pkg::OP_DUP, sme_pkg::OP_ADD,
        sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV, sme_pkg::OP_MOD,
        sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_NOT,
        sme_pkg::OP_EQ, sme_pkg::OP_NEQ, sme_pkg::OP_LT, sme_pkg::OP_GT,
        sme_pkg::OP_LOAD, sme_pkg::OP_STOR, sme_pkg::OP_PRTD};
    logic [31:0] phase_len[4] = '{32'd4096, 32'd8191, 32'd500, 32'd4095};

    stack_machine_executor i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] stack_pop();
        if (model_depth == 0)
            return 32'd0;
        model_depth--;
        return model_stack[model_depth];
    endfunction

    function automatic void stack_push(logic [31:0] v);
        if (model_depth < sme_pkg::STACK_DEPTH)
        begin
            model_stack[model_depth] = v;
            model_depth++;
        end
    endfunction

    function automatic logic [31:0] signed_quot(logic [31:0] a, logic [31:0] b, bit rem);
        if (b == 32'd0)
            return 32'd0;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            return rem ? 32'd0 : 32'h8000_0000;
        return rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
    endfunction

    function automatic exec_result_t execute_step(logic [7:0] op, logic [31:0] imm_in);
        exec_result_t r;
        logic [31:0]  len;
        logic [31:0]  pc;
        logic [31:0]  n;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  imm;
        imm = imm_in;
        r = '0;
        len = model_len < sme_pkg::CODE_BYTES ? model_len : sme_pkg::CODE_BYTES;
        if (model_running && model_pc >= len)
        begin
            model_running = 0;
            model_cause = sme_pkg::ST_END;
        end
        if (model_running)
        begin
            pc = model_pc + 1;
            if (sme_pkg::has_imm(op))
            begin
                n = len - pc;
                if (n > 4)
                    n = 4;
                if (n < 4)
                    imm = imm & ((32'd1 << (8 * n)) - 1);
                pc = pc + n;
            end
            case (op)
                sme_pkg::OP_NOP: ;
                sme_pkg::OP_HALT:
                begin
                    model_running = 0;
                    model_cause = sme_pkg::ST_HALT;
                end
                sme_pkg::OP_PUSH: stack_push(imm);
                sme_pkg::OP_POP: a = stack_pop();
                sme_pkg::OP_DUP:
                begin
                    a = stack_pop();
                    stack_push(a);
                    stack_push(a);
                end
                sme_pkg::OP_NOT:
                begin
                    a = stack_pop();
                    stack_push(a == 0 ? 32'd1 : 32'd0);
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD, sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_XOR,
                sme_pkg::OP_EQ, sme_pkg::OP_NEQ, sme_pkg::OP_LT, sme_pkg::OP_GT:
                begin
                    b = stack_pop();
                    a = stack_pop();
                    case (op)
                        sme_pkg::OP_ADD: stack_push(a + b);
                        sme_pkg::OP_SUB: stack_push(a - b);
                        sme_pkg::OP_MUL: stack_push(a * b);
                        sme_pkg::OP_DIV: stack_push(signed_quot(a, b, 0));
                        sme_pkg::OP_MOD: stack_push(signed_quot(a, b, 1));
                        sme_pkg::OP_AND: stack_push(a & b);
                        sme_pkg::OP_OR:  stack_push(a | b);
                        sme_pkg::OP_XOR: stack_push(a ^ b);
                        sme_pkg::OP_EQ:  stack_push({31'd0, a == b});
                        sme_pkg::OP_NEQ: stack_push({31'd0, a != b});
                        sme_pkg::OP_LT:  stack_push({31'd0, $signed(a) < $signed(b)});
                        default: stack_push({31'd0, $signed(b) < $signed(a)});
                    endcase
                end
                sme_pkg::OP_JMP: pc = imm;
                sme_pkg::OP_JZ:
                begin
                    a = stack_pop();
                    if (a == 0)
                        pc = imm;
                end
                sme_pkg::OP_JNZ:
                begin
                    a = stack_pop();
                    if (a != 0)
                        pc = imm;
                end
                sme_pkg::OP_LOAD:
                begin
                    a = stack_pop();
                    stack_push(a < sme_pkg::DATA_WORDS ? model_mem[a] : 32'd0);
                end
                sme_pkg::OP_STOR:
                begin
                    b = stack_pop();
                    a = stack_pop();
                    if (a < sme_pkg::DATA_WORDS)
                        model_mem[a] = b;
                end
                sme_pkg::OP_PRTD, sme_pkg::OP_PRTT:
                begin
                    r.print_value = stack_pop();
                    r.print_valid = 1;
                    r.print_mode = op[0];
                end
                default:
                begin
                    model_running = 0;
                    model_cause = sme_pkg::ST_BADOP;
                end
            endcase
            model_pc = pc;
            if (model_running && model_pc >= len)
            begin
                model_running = 0;
                model_cause = sme_pkg::ST_END;
            end
        end
        r.next_pc = model_pc;
        r.run_status = model_running ? sme_pkg::ST_RUN : model_cause;
        return r;
    endfunction

    task automatic send_item(logic [7:0] op, logic [31:0] imm, bit typed, exec_result_t typed_res);
        int gap;
        exec_result_t r;
        gap = 0;
        if (!no_idle)
        begin
            case ($urandom_range(0, 99)) inside
                [0:59]:  gap = 0;
                [60:94]: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(10, 40);
            endcase
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {imm, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = execute_step(op, imm);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic send_plain(logic [7:0] op, logic [31:0] imm);
        send_item(op, imm, 0, '0);
    endtask

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_length(logic [31:0] len);
        cfg_we <= 1'b1;
        cfg_wdata <= len[sme_pkg::LEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        model_len = len & 32'h1FFF;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom_range(0, 1100);
            6, 7: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] len;
        int          r;
        len = model_len < sme_pkg::CODE_BYTES ? model_len : sme_pkg::CODE_BYTES;
        r = $urandom_range(0, 99);
        if (model_pc + 16 > len)
            send_plain(sme_pkg::OP_JMP, $urandom_range(0, len / 2));
        else if (r < 40)
            send_plain(sme_pkg::OP_PUSH, pick_value());
        else if (r < 46)
            send_plain($urandom_range(0, 1) ? sme_pkg::OP_JZ : sme_pkg::OP_JNZ,
                       $urandom_range(0, len - 16));
        else if (r < 49)
            send_plain(sme_pkg::OP_JMP, $urandom_range(0, len - 16));
        else if (r < 53)
            send_plain(sme_pkg::OP_PRTT, $urandom);
        else
            send_plain(misc_ops[$urandom_range(0, 18)], $urandom);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        exec_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.next_pc)
                    report_mismatch("next_pc", m_tdata[31:0], want.next_pc);
                if (m_tdata[32] !== want.print_valid)
                    report_mismatch("print_valid", m_tdata[32], want.print_valid);
                if (m_tuser !== want.print_mode)
                    report_mismatch("print_mode", m_tuser, want.print_mode);
                if (m_tdata[64:33] !== want.print_value)
                    report_mismatch("print_value", m_tdata[64:33], want.print_value);
                if (m_tdata[66:65] !== want.run_status)
                    report_mismatch("run_status", m_tdata[66:65], want.run_status);
            end
        end
    end

    int stall_left;
    always @(posedge clk)
    begin
        if (no_idle)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 99)) inside
                [0:69]:  stall_left <= 0;
                [70:95]: stall_left <= $urandom_range(1, 4);
                default: stall_left <= $urandom_range(10, 50);
            endcase
        end
    end

    table_row_t stim_table[25];

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        errors = 0;
        no_idle = 0;
        stall_left = 0;
        model_depth = 0;
        model_pc = 0;
        model_running = 1;
        model_cause = sme_pkg::ST_RUN;
        model_len = 0;
        foreach (model_stack[i])
            model_stack[i] = '0;
        foreach (model_mem[i])
            model_mem[i] = '0;

        stim_table[0]  = '{sme_pkg::OP_PUSH, 32'h7FFF_FFFF, 0, '0};
        stim_table[1]  = '{sme_pkg::OP_PUSH, 32'h8000_0000, 0, '0};
        stim_table[2]  = '{sme_pkg::OP_ADD,  32'd0, 0, '0};
        stim_table[3]  = '{sme_pkg::OP_PRTD, 32'd0, 1,
                           '{32'd12, 1'b1, 1'b0, 32'hFFFF_FFFF, sme_pkg::ST_RUN}};
        stim_table[4]  = '{sme_pkg::OP_POP,  32'hFFFF_FFFF, 0, '0};
        stim_table[5]  = '{sme_pkg::OP_PRTT, 32'd0, 1,
                           '{32'd14, 1'b1, 1'b1, 32'd0, sme_pkg::ST_RUN}};
        stim_table[6]  = '{sme_pkg::OP_PUSH, 32'h8000_0000, 0, '0};
        stim_table[7]  = '{sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 0, '0};
        stim_table[8]  = '{sme_pkg::OP_DIV,  32'd0, 0, '0};
        stim_table[9]  = '{sme_pkg::OP_PRTD, 32'd0, 1,
                           '{32'd26, 1'b1, 1'b0, 32'h8000_0000, sme_pkg::ST_RUN}};
        stim_table[10] = '{sme_pkg::OP_PUSH, 32'h8000_0000, 0, '0};
        stim_table[11] = '{sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 0, '0};
        stim_table[12] = '{sme_pkg::OP_MOD,  32'd0, 0, '0};
        stim_table[13] = '{sme_pkg::OP_PRTD, 32'd0, 1,
                           '{32'd38, 1'b1, 1'b0, 32'd0, sme_pkg::ST_RUN}};
        stim_table[14] = '{sme_pkg::OP_PUSH, 32'd5, 0, '0};
        stim_table[15] = '{sme_pkg::OP_PUSH, 32'd0, 0, '0};
        stim_table[16] = '{sme_pkg::OP_DIV,  32'd0, 0, '0};
        stim_table[17] = '{sme_pkg::OP_PRTT, 32'd0, 1,
                           '{32'd50, 1'b1, 1'b1, 32'd0, sme_pkg::ST_RUN}};
        stim_table[18] = '{sme_pkg::OP_PUSH, 32'd2000, 0, '0};
        stim_table[19] = '{sme_pkg::OP_LOAD, 32'd0, 0, '0};
        stim_table[20] = '{sme_pkg::OP_PRTD, 32'd0, 1,
                           '{32'd57, 1'b1, 1'b0, 32'd0, sme_pkg::ST_RUN}};
        stim_table[21] = '{sme_pkg::OP_PUSH, 32'd1023, 0, '0};
        stim_table[22] = '{sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 0, '0};
        stim_table[23] = '{sme_pkg::OP_STOR, 32'd0, 0, '0};
        stim_table[24] = '{sme_pkg::OP_JMP,  32'd0, 1,
                           '{32'd0, 1'b0, 1'b0, 32'd0, sme_pkg::ST_RUN}};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_length(32'd4096);

        foreach (stim_table[i])
            send_item(stim_table[i].func, stim_table[i].imm, stim_table[i].typed,
                      stim_table[i].result);

        foreach (phase_len[p])
        begin
            send_plain(sme_pkg::OP_JMP, $urandom_range(0, 100));
            drain_and_wait();
            write_length(phase_len[p]);
            no_idle = 1;
            for (int i = 0; i < 250; i++)
            begin
                if (i == 40)
                    no_idle = 0;
                if (i == 150)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                if (p == 1 && i == 200)
                begin
                    for (int k = 0; k < 270; k++)
                    begin
                        if (model_pc + 16 > 4096)
                            send_plain(sme_pkg::OP_JMP, 32'd0);
                        else
                            send_plain(sme_pkg::OP_PUSH, $urandom);
                    end
                end
                send_random();
            end
        end

        // truncated immediate runs the counter onto the program end
        send_plain(sme_pkg::OP_JMP, 32'd100);
        drain_and_wait();
        write_length(32'd103);
        send_plain(sme_pkg::OP_PUSH, 32'h1234_5678);
        send_plain(sme_pkg::OP_HALT, 32'd0);
        send_plain(8'hFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 20; i++)
            send_plain($urandom_range(0, 255), $urandom);

        drain_and_wait();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* files.f */
rtl/core/sme_pkg.sv
rtl/core/sme_ram.sv
rtl/core/sme_div.sv
rtl/core/sme_datapath.sv
rtl/core/sme_ctrl.sv
rtl/core/stack_machine_executor.sv
tb/stack_machine_executor_test.sv
